[hdl/assert_macros.svh]
// Assertion macros shared by the RTL of the frame receiver.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/pdfr_pkg.sv]
// Package of the pulse duty frame receiver: types, codes and constants.
// No dependencies; compiled first.
package pdfr_pkg;

   localparam int BufferBytesDefault = 16;
   localparam int LastBitPos         = 7;    // last data bit position, MSB first
   localparam int TimeoutWidth       = 8;
   localparam logic [TimeoutWidth-1:0] TimeoutReset = 8'd255;

   // controller states
   typedef enum logic [2:0] {
      ST_RUN  = 3'b001,
      ST_READ = 3'b010,
      ST_LOAD = 3'b100
   } pdfr_state_type;

   // line decoder phases
   typedef enum logic [3:0] {
      PH_IDLE = 4'b0001,
      PH_LEAD = 4'b0010,
      PH_HIGH = 4'b0100,
      PH_LOW  = 4'b1000
   } pdfr_phase_type;

   typedef struct packed {
      logic sample_en;   // take one line sample
      logic mem_rd;      // read byte store at drain index
      logic out_load;    // move read byte into output register
   } pdfr_cmd_type;

   typedef struct packed {
      logic frame_done;  // current sample ends a frame
      logic abort;       // current sample times out a run
      logic out_free;    // output register empty or emptying
      logic drain_last;  // drain index at final byte of frame
   } pdfr_status_type;

endpackage

[hdl/pdfr_req_if.sv]
// Sample channel of the frame receiver: valid/ready plus one line level.
// No dependencies.
interface pdfr_req_if;
   logic valid;
   logic ready;
   logic line_level;

   modport source (output valid, output line_level, input ready);
   modport sink   (input valid, input line_level, output ready);
endinterface

[hdl/pdfr_rsp_if.sv]
// Result channel of the frame receiver: valid/ready plus byte and flags.
// No dependencies.
interface pdfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_status;
   logic       last_of_frame;

   modport source (output valid, output data_byte, output frame_status,
                   output last_of_frame, input ready);
   modport sink   (input valid, input data_byte, input frame_status,
                   input last_of_frame, output ready);
endinterface

[hdl/pulse_duty_frame_receiver_unit.sv]
// Top level of the pulse duty frame receiver: controller plus datapath.
// Depends on pdfr_pkg, pdfr_req_if, pdfr_rsp_if, pdfr_ctrl and pdfr_datapath.
//
// Usage:
//  req_ch carries one sampled line level per transaction. While the block
//   is decoding, req_ch.ready follows the result register: a sample is taken
//   every cycle as long as the result register is empty or being emptied.
//  rsp_ch carries one result per transaction: a byte with status 0, or a
//   single abort result (byte 0, status 1) when a run exceeds the timeout.
//   last_of_frame marks the final result of a frame.
//  csr_write_en/csr_write_data load the timeout (samples per run); write
//   only while idle. Reset value is 255.
// Throughput and ordering:
//  one sample per cycle while decoding, as long as the result register is empty
//   or being emptied. An abort result is visible the cycle after the sample that
//   caused it. The sample ending a frame starts a drain of N stored bytes: the
//   byte store has one registered read port, so each byte is read, then loaded
//   into the result register, and samples are held off for the whole drain.
// Reset clears decoder state, the controller and the result valid; the byte
//   store needs no clearing since only bytes of the current frame are read.
// A stalled receiver (rsp_ch.ready low) holds the pending result and blocks
//   intake or the drain until it is taken.

module pulse_duty_frame_receiver_unit #(
   parameter int BUFFER_BYTES = pdfr_pkg::BufferBytesDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   pdfr_req_if.sink                          req_ch,
   pdfr_rsp_if.source                        rsp_ch,
   input  logic                              csr_write_en,
   input  logic [pdfr_pkg::TimeoutWidth-1:0] csr_write_data
);
   import pdfr_pkg::*;

   pdfr_cmd_type    cmd;      // controller to datapath
   pdfr_status_type status;   // datapath to controller
   logic            ready_w;

   pdfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (ready_w),
      .status    (status),
      .cmd       (cmd)
   );

   pdfr_datapath #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .line_level     (req_ch.line_level),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .cmd            (cmd),
      .status         (status),
      .rsp            (rsp_ch)
   );

   assign req_ch.ready = ready_w;

endmodule

[hdl/pdfr_ctrl.sv]
// Controller of the frame receiver: sample intake and frame drain sequencing.
// Depends on pdfr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pdfr_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  pdfr_pkg::pdfr_status_type status,
   output pdfr_pkg::pdfr_cmd_type    cmd
);
   import pdfr_pkg::*;

   pdfr_state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_RUN: begin
            req_ready     = status.out_free;
            cmd.sample_en = req_valid && status.out_free;
            if (cmd.sample_en && status.frame_done) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_LOAD;
         end
         ST_LOAD: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = status.drain_last ? ST_RUN : ST_READ;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

   `ASSERT_IMPLIES(a_no_intake_in_drain, clock, reset, state_ff != ST_RUN, !req_ready,
                   "sample taken during drain")
   `ASSERT_NEXT(a_drain_returns, clock, reset, cmd.out_load && status.drain_last,
                state_ff == ST_RUN && !cmd.mem_rd, "drain did not end after last byte")
   `ASSERT_IMPLIES(a_abort_not_done, clock, reset, status.abort, !status.frame_done,
                   "abort and frame end on one sample")

endmodule

[hdl/pdfr_datapath.sv]
// Datapath of the frame receiver: run counters, bit decode, byte store, output register.
// Depends on pdfr_pkg, pdfr_rsp_if and assert_macros.svh.
`include "assert_macros.svh"

module pdfr_datapath #(
   parameter int BUFFER_BYTES = pdfr_pkg::BufferBytesDefault
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   line_level,
   input  logic                                   csr_write_en,
   input  logic [pdfr_pkg::TimeoutWidth-1:0]      csr_write_data,
   input  pdfr_pkg::pdfr_cmd_type                 cmd,
   output pdfr_pkg::pdfr_status_type              status,
   pdfr_rsp_if.source                             rsp
);
   import pdfr_pkg::*;

   localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
   localparam int CW = $clog2(BUFFER_BYTES + 1);
   localparam int TW = TimeoutWidth;

   logic [TW-1:0]  timeout_ff;
   pdfr_phase_type phase_ff, phase_in;
   logic [TW-1:0]  high_ff, high_in, low_ff, low_in;
   logic [3:0]     bitpos_ff, bitpos_in;
   logic [7:0]     shift_ff, shift_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  frame_len_ff;
   logic [AW-1:0]  drain_idx_ff;
   logic [7:0]     byte_mem [BUFFER_BYTES];
   logic [7:0]     rd_data_ff;
   logic           st_we;

   logic           rsp_valid_ff;
   logic [7:0]     rsp_byte_ff;
   logic           rsp_status_ff;
   logic           rsp_last_ff;

   logic [TW:0]    sum, inc_high, inc_low, limit;
   logic           bit_val, zero_to;
   logic           abort, frame_done;

   // pulse-width decode: 9-bit sum, bit is 1 when high run exceeds half
   assign sum      = {1'b0, high_ff} + {1'b0, low_ff};
   assign bit_val  = high_ff > sum[TW:1];
   assign inc_high = {1'b0, high_ff} + 1'b1;
   assign inc_low  = {1'b0, low_ff} + 1'b1;
   assign limit    = {1'b0, timeout_ff};
   assign zero_to  = (timeout_ff == '0);   // a fresh run of one already times out

   always_comb begin
      phase_in   = phase_ff;
      high_in    = high_ff;
      low_in     = low_ff;
      bitpos_in  = bitpos_ff;
      shift_in   = shift_ff;
      count_in   = count_ff;
      st_we      = 1'b0;
      abort      = 1'b0;
      frame_done = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (!line_level) begin
               phase_in = PH_LEAD;
               if (zero_to) abort = 1'b1;
               else low_in = 8'd1;
            end
         end
         PH_LEAD: begin
            if (!line_level) begin
               if (inc_low > limit) abort = 1'b1;
               else low_in = inc_low[TW-1:0];
            end else begin
               phase_in = PH_HIGH;
               if (zero_to) abort = 1'b1;
               else high_in = 8'd1;
            end
         end
         PH_HIGH: begin
            if (line_level) begin
               if (inc_high > limit) abort = 1'b1;
               else high_in = inc_high[TW-1:0];
            end else begin
               phase_in = PH_LOW;
               if (zero_to) abort = 1'b1;
               else low_in = 8'd1;
            end
         end
         PH_LOW: begin
            if (!line_level) begin
               if (inc_low > limit) abort = 1'b1;
               else low_in = inc_low[TW-1:0];
            end else begin
               if (bitpos_ff <= 4'(LastBitPos)) begin
                  shift_in  = {shift_ff[6:0], bit_val};
                  bitpos_in = bitpos_ff + 4'd1;
                  if (bitpos_ff == 4'(LastBitPos)) begin
                     st_we    = (count_ff < CW'(BUFFER_BYTES));
                     count_in = count_ff + 1'b1;
                  end
               end else if (bit_val || count_ff >= CW'(BUFFER_BYTES)) begin
                  frame_done = 1'b1;
               end else begin
                  bitpos_in = '0;
                  shift_in  = '0;
               end
               if (!frame_done) begin
                  phase_in = PH_HIGH;
                  if (zero_to) abort = 1'b1;
                  else high_in = 8'd1;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
      if (abort || frame_done) begin
         phase_in  = PH_IDLE;
         high_in   = '0;
         low_in    = '0;
         bitpos_in = '0;
         shift_in  = '0;
         count_in  = '0;
      end
   end

   always_comb begin
      status.frame_done = frame_done;
      status.abort      = abort;
      status.out_free   = !rsp_valid_ff || rsp.ready;
      status.drain_last = (CW'(drain_idx_ff) + 1'b1) == frame_len_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TimeoutReset;
         phase_ff     <= PH_IDLE;
         high_ff      <= '0;
         low_ff       <= '0;
         bitpos_ff    <= '0;
         shift_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            timeout_ff <= csr_write_data;
         end
         if (cmd.sample_en) begin
            phase_ff  <= phase_in;
            high_ff   <= high_in;
            low_ff    <= low_in;
            bitpos_ff <= bitpos_in;
            shift_ff  <= shift_in;
            count_ff  <= count_in;
         end
         if ((cmd.sample_en && abort) || cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // frame drain bookkeeping and output payload
   always_ff @(posedge clock) begin
      if (cmd.sample_en && frame_done) begin
         frame_len_ff <= count_ff;
         drain_idx_ff <= '0;
      end else if (cmd.out_load) begin
         drain_idx_ff <= drain_idx_ff + 1'b1;
      end
      if (cmd.sample_en && abort) begin
         rsp_byte_ff   <= '0;
         rsp_status_ff <= 1'b1;
         rsp_last_ff   <= 1'b1;
      end else if (cmd.out_load) begin
         rsp_byte_ff   <= rd_data_ff;
         rsp_status_ff <= 1'b0;
         rsp_last_ff   <= status.drain_last;
      end
   end

   // byte store
   always_ff @(posedge clock) begin
      if (cmd.sample_en && st_we) begin
         byte_mem[count_ff[AW-1:0]] <= shift_in;
      end
      if (cmd.mem_rd) begin
         rd_data_ff <= byte_mem[drain_idx_ff];
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.data_byte     = rsp_byte_ff;
   assign rsp.frame_status  = rsp_status_ff;
   assign rsp.last_of_frame = rsp_last_ff;

   `ASSERT_IMPLIES(a_no_overwrite, clock, reset, cmd.out_load || (cmd.sample_en && abort),
                   !rsp_valid_ff || rsp.ready, "pending result overwritten")
   `ASSERT_NEXT(a_abort_result, clock, reset, cmd.sample_en && abort,
                rsp.valid && rsp.frame_status && rsp.last_of_frame && rsp.data_byte == 8'd0,
                "abort result malformed")
   `ASSERT_IMPLIES(a_count_in_range, clock, reset, 1'b1, count_ff <= CW'(BUFFER_BYTES),
                   "byte count past buffer size")

endmodule

[tb/pulse_duty_frame_receiver_unit_test.sv]
// Self-checking testbench of the pulse duty frame receiver top level.
// Depends on pdfr_pkg, pdfr_req_if, pdfr_rsp_if and pulse_duty_frame_receiver_unit.
`timescale 1ns / 100ps

module pulse_duty_frame_receiver_unit_test;
   import pdfr_pkg::*;

   localparam int BufferBytes   = BufferBytesDefault;
   localparam int WatchdogLimit = 2000;  // cycles without any transaction
   localparam int HoldOffCycles = 250;   // long receiver stall for the pressure phase
   localparam int SettleCycles  = 48;    // covers a full drain plus margin

   // one result transaction as the receiver sees it
   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_status;
      logic       last_of_frame;
   } frame_result_type;

   // ------------------------------------------------------------------
   // Scoreboard: a bit-exact decoder of the line samples plus the queue of
   // results that decoder says are due. note_sample runs on every accepted
   // sample transaction, check_result on every accepted result transaction.
   // ------------------------------------------------------------------
   class frame_scoreboard;
      pdfr_phase_type   phase;
      logic [7:0]       timeout;
      logic [7:0]       high_run;
      logic [7:0]       low_run;
      logic [3:0]       bit_pos;
      logic [7:0]       shift_byte;
      logic [4:0]       byte_count;
      logic [7:0]       byte_store [BufferBytes];
      frame_result_type due_results [$];
      int               errors;

      function new();
         timeout = TimeoutReset;
         errors  = 0;
         clear_frame();
      endfunction

      function void set_timeout(logic [7:0] value);
         timeout = value;
      endfunction

      function void clear_frame();
         phase      = PH_IDLE;
         high_run   = '0;
         low_run    = '0;
         bit_pos    = '0;
         shift_byte = '0;
         byte_count = '0;
      endfunction

      function void report(string text);
         errors++;
         if (errors <= 10) $display("[%0t] mismatch: %s", $time, text);
      endfunction

      // one more sample on a run; 0 when the run would pass the timeout
      function bit extend(logic [7:0] run, bit restart, output logic [7:0] grown);
         logic [8:0] next;
         next  = restart ? 9'd1 : {1'b0, run} + 9'd1;
         grown = run;
         if (next > {1'b0, timeout}) return 1'b0;
         grown = next[7:0];
         return 1'b1;
      endfunction

      function void abort_frame();
         frame_result_type r;
         r.data_byte     = 8'h00;
         r.frame_status  = 1'b1;
         r.last_of_frame = 1'b1;
         due_results.push_back(r);
         clear_frame();
      endfunction

      function void release_frame();
         frame_result_type r;
         for (int k = 0; k < byte_count && k < BufferBytes; k++) begin
            r.data_byte     = byte_store[k];
            r.frame_status  = 1'b0;
            r.last_of_frame = (k + 1 == byte_count);
            due_results.push_back(r);
         end
         clear_frame();
      endfunction

      // low run closed by a high sample: decide the bit from the 9-bit sum
      function void decode_bit();
         logic [8:0] sum;
         logic       dec;
         sum = {1'b0, high_run} + {1'b0, low_run};
         dec = high_run > sum[8:1];
         if (bit_pos <= LastBitPos) begin
            shift_byte = {shift_byte[6:0], dec};
            bit_pos++;
            if (bit_pos > LastBitPos) begin
               if (byte_count < BufferBytes) byte_store[byte_count] = shift_byte;
               byte_count++;
            end
         end else begin
            if (dec || byte_count >= BufferBytes) begin
               release_frame();
               return;
            end
            bit_pos    = '0;
            shift_byte = '0;
         end
         phase = PH_HIGH;
         if (!extend(high_run, 1'b1, high_run)) abort_frame();
      endfunction

      function void note_sample(logic lvl);
         case (phase)
            PH_IDLE: begin
               if (!lvl) begin
                  phase = PH_LEAD;
                  if (!extend(low_run, 1'b1, low_run)) abort_frame();
               end
            end
            PH_LEAD: begin
               if (!lvl) begin
                  if (!extend(low_run, 1'b0, low_run)) abort_frame();
               end else begin
                  phase = PH_HIGH;
                  if (!extend(high_run, 1'b1, high_run)) abort_frame();
               end
            end
            PH_HIGH: begin
               if (lvl) begin
                  if (!extend(high_run, 1'b0, high_run)) abort_frame();
               end else begin
                  phase = PH_LOW;
                  if (!extend(low_run, 1'b1, low_run)) abort_frame();
               end
            end
            default: begin
               if (!lvl) begin
                  if (!extend(low_run, 1'b0, low_run)) abort_frame();
               end else begin
                  decode_bit();
               end
            end
         endcase
      endfunction

      function void check_result(logic [7:0] got_byte, logic got_status, logic got_last);
         frame_result_type want;
         if (due_results.size() == 0) begin
            report($sformatf("result with none due: byte %02h status %0b last %0b",
                             got_byte, got_status, got_last));
            return;
         end
         want = due_results.pop_front();
         if (want.data_byte !== got_byte)
            report($sformatf("data_byte want %02h got %02h", want.data_byte, got_byte));
         if (want.frame_status !== got_status)
            report($sformatf("frame_status want %0b got %0b", want.frame_status, got_status));
         if (want.last_of_frame !== got_last)
            report($sformatf("last_of_frame want %0b got %0b", want.last_of_frame, got_last));
      endfunction
   endclass

   // ------------------------------------------------------------------
   // Clock, reset, channels and the block
   // ------------------------------------------------------------------
   logic       clock = 1'b0;
   logic       reset;
   logic       csr_write_en;
   logic [7:0] csr_write_data;

   pdfr_req_if req_ch ();
   pdfr_rsp_if rsp_ch ();

   pulse_duty_frame_receiver_unit #(
      .BUFFER_BYTES (BufferBytes)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always #2 clock = ~clock;

   frame_scoreboard sb;
   logic            sample_stream [$];   // line levels still to be offered
   logic [7:0]      cur_timeout;         // timeout the stimulus is shaped for
   int              stall_pct;           // receiver stall rate, percent
   int              hold_token;          // bumped to request a long hold-off
   int              hold_seen;
   int              hold_left;
   int              quiet_cycles;
   bit              took;

   // ------------------------------------------------------------------
   // Receiver: random stalls; a bump of hold_token starts a long hold-off
   // that this process counts down on its own.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen    <= hold_token;
         hold_left    <= HoldOffCycles;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left    <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
      end
   end

   // ------------------------------------------------------------------
   // Monitor: feeds accepted samples to the decoder, checks accepted results,
   // and ends the run when nothing moves for too long.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         took = 1'b0;
         if (req_ch.valid && req_ch.ready) begin
            sb.note_sample(req_ch.line_level);
            took = 1'b1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            sb.check_result(rsp_ch.data_byte, rsp_ch.frame_status, rsp_ch.last_of_frame);
            took = 1'b1;
         end
         quiet_cycles <= took ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("[%0t] watchdog: no transaction for %0d cycles", $time, quiet_cycles);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus builders: they append line levels to sample_stream.
   // A bit is a high run h then a low run l; it decodes as 1 exactly
   // when h > l, a tie decodes as 0.
   // ------------------------------------------------------------------
   function automatic int run_cap(int cap);
      int m;
      m = (cap < cur_timeout) ? cap : cur_timeout;
      return (m < 1) ? 1 : m;
   endfunction

   task automatic add_run(logic lvl, int n);
      repeat (n) sample_stream.push_back(lvl);
   endtask

   task automatic add_bit(logic value, int cap);
      int m, h, l;
      m = run_cap(cap);
      if (value && m >= 2) begin
         l = $urandom_range(m - 1, 1);
         h = $urandom_range(m, l + 1);
      end else begin
         h = $urandom_range(m, 1);
         l = $urandom_range(m, h);
      end
      add_run(1'b1, h);
      add_run(1'b0, l);
   endtask

   // eight data bits MSB first, then the end bit
   task automatic add_byte(logic [7:0] value, logic end_bit, int cap);
      for (int i = 7; i >= 0; i--) add_bit(value[i], cap);
      add_bit(end_bit, cap);
   endtask

   // leading low, bytes, and the high sample that closes the last low run
   task automatic add_frame(int nbytes, int cap, logic last_end);
      add_run(1'b0, $urandom_range(run_cap(cap), 1));
      for (int i = 0; i < nbytes; i++)
         add_byte(8'($urandom_range(255, 0)), (i == nbytes - 1) ? last_end : 1'b0, cap);
      add_run(1'b1, 1);
   endtask

   // mostly well-formed frames; the rest is noise, timeouts, cut-off frames
   task automatic add_traffic(int n_items, int cap);
      int kind, nbytes;
      for (int j = 0; j < n_items; j++) begin
         kind = $urandom_range(99, 0);
         if (kind < 70) begin
            nbytes = ($urandom_range(19, 0) == 0) ? BufferBytes : $urandom_range(4, 1);
            add_frame(nbytes, cap, (nbytes == BufferBytes) ? logic'($urandom_range(1, 0))
                                                           : 1'b1);
         end else if (kind < 80) begin
            repeat ($urandom_range(20, 1)) add_run(logic'($urandom_range(1, 0)),
                                                   $urandom_range(3, 1));
         end else if (kind < 90) begin
            // run past the timeout partway into a frame
            add_run(1'b0, $urandom_range(run_cap(cap), 1));
            repeat ($urandom_range(20, 0)) add_bit(logic'($urandom_range(1, 0)), cap);
            add_run(logic'($urandom_range(1, 0)), cur_timeout + 1);
         end else begin
            // idle highs, then a frame that just stops
            add_run(1'b1, $urandom_range(5, 1));
            add_run(1'b0, $urandom_range(run_cap(cap), 1));
            repeat ($urandom_range(30, 1)) add_bit(logic'($urandom_range(1, 0)), cap);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Drivers. All are entered at a rising edge and drive with NBAs.
   // ------------------------------------------------------------------
   task automatic write_timeout(logic [7:0] value);
      csr_write_data <= value;
      csr_write_en   <= 1'b1;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      sb.set_timeout(value);
      cur_timeout = value;
   endtask

   // wait for every due result, then let a drain or a decode finish
   task automatic settle();
      while (sb.due_results.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic start_phase(logic [7:0] timeout_value, int stall);
      settle();
      write_timeout(timeout_value);
      stall_pct <= stall;
      sample_stream.delete();
   endtask

   // offer the stream; a long high tail returns the decoder to idle in
   // every phase, so the next register write always lands while idle
   task automatic send_samples(int idle_pct);
      int idx;
      add_run(1'b1, cur_timeout + 2);
      idx = 0;
      while (idx < sample_stream.size()) begin
         if ($urandom_range(99, 0) < idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end else begin
            req_ch.valid      <= 1'b1;
            req_ch.line_level <= sample_stream[idx];
            @(posedge clock);
            while (!req_ch.ready) @(posedge clock);
            idx++;
         end
      end
      req_ch.valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      sb                = new();
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.line_level = 1'b0;
      rsp_ch.ready      = 1'b0;
      csr_write_en      = 1'b0;
      csr_write_data    = '0;
      stall_pct         = 0;
      hold_token        = 0;
      hold_seen         = 0;
      hold_left         = 0;
      quiet_cycles      = 0;
      cur_timeout       = TimeoutReset;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed, widest timeout, no idling on either side.
      start_phase(8'd255, 0);
      add_run(1'b1, 3);                      // idle highs are ignored
      add_run(1'b0, 2);
      add_byte(8'h00, 1'b0, 4);
      add_byte(8'hFF, 1'b1, 4);
      add_run(1'b1, 1);
      // long runs: the bit decision needs the full 9-bit sum
      add_run(1'b0, 1);
      add_run(1'b1, 200); add_run(1'b0, 200); // tie -> 0
      add_run(1'b1, 130); add_run(1'b0, 140); // 0, would be 1 with an 8-bit sum
      add_run(1'b1, 255); add_run(1'b0, 254); // 1 at the run limit
      add_run(1'b1, 255); add_run(1'b0, 255); // tie at the limit -> 0
      repeat (4) add_bit(logic'($urandom_range(1, 0)), 6);
      add_bit(1'b1, 4);
      add_run(1'b1, 1);
      add_run(1'b0, 256);                    // leading low times out
      add_run(1'b0, 1); add_run(1'b1, 256);  // high run times out
      add_run(1'b0, 1); add_run(1'b1, 2); add_run(1'b0, 256); // low run times out
      add_frame(BufferBytes, 2, 1'b1);       // full buffer, end bit set
      add_run(1'b0, 1);
      add_byte(8'hA5, 1'b1, 5);
      add_run(1'b1, 1);
      send_samples(0);

      // Timeout 1: every bit is a 1/1 tie, so frames end only on a full buffer.
      start_phase(8'd1, 0);
      add_frame(BufferBytes, 1, 1'b0);
      add_run(1'b0, 2);                      // lead past one sample
      add_run(1'b0, 1); add_run(1'b1, 2);    // high past one sample
      add_frame(BufferBytes, 1, 1'b1);
      send_samples(60);

      // Timeout 0: any low aborts at once.
      start_phase(8'd0, 60);
      add_run(1'b1, 2); add_run(1'b0, 3); add_run(1'b1, 1); add_run(1'b0, 1);
      send_samples(0);

      // Random traffic, both sides idling.
      start_phase(8'($urandom_range(40, 8)), 28);
      add_traffic(14, 8);
      send_samples(28);

      // Pressure: receiver holds off while the sender keeps offering, so the
      // result register fills and the sample channel backs up.
      start_phase(8'd255, 0);
      repeat (6) add_frame(1, 2, 1'b1);
      hold_token <= hold_token + 1;
      send_samples(0);

      // Tight timeout, frequent aborts, sender idling.
      start_phase(8'($urandom_range(6, 2)), 0);
      add_traffic(12, 6);
      send_samples(60);

      // Wide timeout, receiver stalling.
      start_phase(8'($urandom_range(255, 100)), 60);
      add_traffic(12, 12);
      send_samples(0);

      settle();
      if (sb.errors == 0 && sb.due_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[pulse_duty_frame_receiver_unit.f]
+incdir+hdl
hdl/pdfr_pkg.sv
hdl/pdfr_req_if.sv
hdl/pdfr_rsp_if.sv
hdl/pdfr_ctrl.sv
hdl/pdfr_datapath.sv
hdl/pulse_duty_frame_receiver_unit.sv
tb/pulse_duty_frame_receiver_unit_test.sv
